// ===== rtl/region_profile_table_defines.svh =====
// ============================================================================
// Region profile table assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ============================================================================
`ifndef REGION_PROFILE_TABLE_DEFINES_SVH
`define REGION_PROFILE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define RPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rpt_pkg.sv =====
// ============================================================================
// Region profile table package
// Request codes, status codes, field layout and the cell bus types.
// ============================================================================
package rpt_pkg;

    localparam int MAX_SLOTS_DEF = 16;

    localparam int KIND_W     = 3;
    localparam int REGION_W   = 16;
    localparam int SLOT_IDX_W = 4;
    localparam int TICK_W     = 32;
    localparam int DUR_W      = 31;
    localparam int USED_W     = 5;
    localparam int STATUS_W   = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] K_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] K_START = 3'd1;
    localparam logic [KIND_W-1:0] K_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] K_READ  = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd4;

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 160;

    // Result field offsets inside m_tdata.
    localparam int O_STATUS = 0;
    localparam int O_SLOT   = O_STATUS + STATUS_W;
    localparam int O_REGION = O_SLOT + SLOT_IDX_W;
    localparam int O_CALLS  = O_REGION + REGION_W;
    localparam int O_TOTAL  = O_CALLS + TICK_W;
    localparam int O_DUR    = O_TOTAL + TICK_W;
    localparam int O_USED   = O_DUR + DUR_W;
    localparam int O_TICK   = O_USED + USED_W;
    localparam int O_END    = O_TICK + TICK_W;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [REGION_W-1:0]   region_id;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [TICK_W-1:0]     tick;
        logic                  fire;
        logic                  alloc;
    } rpt_cmd_t;

    // Report from one cell; all zero unless the cell is selected.
    typedef struct packed {
        logic                sel;
        logic [REGION_W-1:0] region;
        logic [TICK_W-1:0]   calls;
        logic [TICK_W-1:0]   total;
        logic [DUR_W-1:0]    dur;
    } rpt_rep_t;

endpackage

// ===== rtl/rpt_cell.sv =====
// ============================================================================
// Region profile table cell
// One table slot: match against the request, allocate from the free head,
// and update entry tick, duration, call count and total in place.
// ============================================================================
module rpt_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpt_pkg::rpt_cmd_t cmd_i,
    input  logic              prev_valid_i,
    output logic              valid_o,
    output logic              hit_o,
    output rpt_pkg::rpt_rep_t rep_o
);
    import rpt_pkg::*;

    localparam bit IDX_OK = (IDX < (1 << SLOT_IDX_W));
    localparam logic [SLOT_IDX_W-1:0] IDX_CODE = IDX[SLOT_IDX_W-1:0];

    logic                valid_reg, valid_next;
    logic [REGION_W-1:0] id_reg, id_next;
    logic [TICK_W-1:0]   entry_reg, entry_next;
    logic [DUR_W-1:0]    dur_reg, dur_next;
    logic [TICK_W-1:0]   calls_reg, calls_next;
    logic [TICK_W-1:0]   total_reg, total_next;

    logic                is_start, is_stop, is_read, is_clear;
    logic                hit, mine_new;
    logic [TICK_W-1:0]   diff;
    logic [DUR_W-1:0]    dur_meas;

    assign is_start = (cmd_i.kind == K_START);
    assign is_stop  = (cmd_i.kind == K_STOP);
    assign is_read  = (cmd_i.kind == K_READ);
    assign is_clear = (cmd_i.kind == K_CLEAR);

    // An allocated slot never holds id zero, so a null id cannot match.
    assign hit = valid_reg &&
                 (((is_start || is_stop) && (id_reg == cmd_i.region_id)) ||
                  (is_read && IDX_OK && (cmd_i.slot_index == IDX_CODE)));

    // The first free cell follows the last allocated neighbor.
    assign mine_new = cmd_i.alloc && prev_valid_i && !valid_reg;

    // Wrap-aware duration, clamped to zero when it points backward.
    assign diff     = cmd_i.tick - entry_reg;
    assign dur_meas = diff[TICK_W-1] ? '0 : diff[DUR_W-1:0];

    // Slot update.
    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        entry_next = entry_reg;
        dur_next   = dur_reg;
        calls_next = calls_reg;
        total_next = total_reg;
        if (cmd_i.fire) begin
            if (is_clear) begin
                valid_next = 1'b0;
            end else if (mine_new) begin
                valid_next = 1'b1;
                id_next    = cmd_i.region_id;
                entry_next = cmd_i.tick;
                dur_next   = '0;
                calls_next = '0;
                total_next = '0;
            end else if (hit && is_start) begin
                entry_next = cmd_i.tick;
            end else if (hit && is_stop) begin
                dur_next   = dur_meas;
                calls_next = calls_reg + TICK_W'(1);
                total_next = total_reg + {1'b0, dur_meas};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        id_reg    <= id_next;
        entry_reg <= entry_next;
        dur_reg   <= dur_next;
        calls_reg <= calls_next;
        total_reg <= total_next;
    end

    // Report of the slot contents as they stand after this request.
    always_comb begin
        rep_o = '0;
        if (mine_new) begin
            rep_o.sel    = 1'b1;
            rep_o.region = cmd_i.region_id;
        end else if (hit) begin
            rep_o.sel    = 1'b1;
            rep_o.region = id_reg;
            if (is_stop) begin
                rep_o.calls = calls_reg + TICK_W'(1);
                rep_o.total = total_reg + {1'b0, dur_meas};
                rep_o.dur   = dur_meas;
            end else begin
                rep_o.calls = calls_reg;
                rep_o.total = total_reg;
                rep_o.dur   = dur_reg;
            end
        end
    end

    assign valid_o = valid_reg;
    assign hit_o   = hit;

endmodule

// ===== rtl/region_profile_table.sv =====
// The controller takes a request in S_IDLE; the row of slot cells matches and
// updates in S_EXEC, which waits while an earlier result is stalled, and the
// result is then registered. No new request is taken until S_EXEC is done.
// Reset clears the tick count, the slot count and every cell valid bit at once;
// no clearing pass is needed and the block is ready once reset is released.
// ============================================================================
// Region profile table
// Tick counter and a row of slot cells keyed by region id, reporting one
// result per request on a registered output.
// ============================================================================
module region_profile_table #(
    parameter int MAX_SLOTS = rpt_pkg::MAX_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: region_id[15:0], slot_index[3:0], zero pad[3:0]
    input  logic [rpt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[2:0]
    input  logic [rpt_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, from bit 0: status[2:0], slot[3:0], slot_region[15:0],
    // calls[31:0], total_ticks[31:0], last_duration[30:0], slots_used[4:0],
    // tick_now[31:0], zero pad[4:0]
    output logic [rpt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rpt_pkg::*;

    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [REGION_W-1:0]     id_reg;
    logic [SLOT_IDX_W-1:0]   idx_reg;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    rpt_cmd_t                cmd;
    logic [MAX_SLOTS-1:0]    valid_vec;
    logic [MAX_SLOTS-1:0]    hit_vec;
    rpt_rep_t                rep_vec [MAX_SLOTS];

    logic                    fire, found, full, alloc;
    rpt_rep_t                rep_sum;
    logic [SLOT_IDX_W-1:0]   slot_sum;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_IDX_W-1:0]   slot_out;
    logic [CW+USED_W-1:0]    count_ext;
    logic [M_TDATA_W-1:0]    result;

    // No request is taken while reset is held.
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign fire     = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign found    = |hit_vec;
    assign full     = valid_vec[MAX_SLOTS-1];
    assign alloc    = fire && (kind_reg == K_START) && (id_reg != '0) && !found && !full;

    // Command broadcast to the cell row.
    assign cmd.kind       = kind_reg;
    assign cmd.region_id  = id_reg;
    assign cmd.slot_index = idx_reg;
    assign cmd.tick       = tick_reg;
    assign cmd.fire       = fire;
    assign cmd.alloc      = alloc;

    // Row of slot cells, each chained to the valid bit of its lower neighbor.
    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        logic prev_valid;
        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = valid_vec[g-1];
        end
        rpt_cell #(
            .IDX (g)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd_i        (cmd),
            .prev_valid_i (prev_valid),
            .valid_o      (valid_vec[g]),
            .hit_o        (hit_vec[g]),
            .rep_o        (rep_vec[g])
        );
    end

    // At most one cell is selected, so the reports combine by OR.
    always_comb begin
        rep_sum  = '0;
        slot_sum = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            rep_sum = rep_sum | rep_vec[i];
            if (rep_vec[i].sel) begin
                slot_sum = slot_sum | SLOT_IDX_W'(i);
            end
        end
    end

    // Status and slot field of the result.
    always_comb begin
        status   = ST_OK;
        slot_out = slot_sum;
        unique case (kind_reg)
            K_START: begin
                if (id_reg == '0) begin
                    status = ST_NULL;
                end else if (!found && full) begin
                    status = ST_FULL;
                end
            end
            K_STOP: begin
                if (id_reg == '0) begin
                    status = ST_NULL;
                end else if (!found) begin
                    status = ST_NOTFOUND;
                end
            end
            K_READ: begin
                if (!found) begin
                    status   = ST_UNUSED;
                    slot_out = idx_reg;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Counters after this request.
    assign tick_next = (kind_reg == K_TICK) ? tick_reg + TICK_W'(1) : tick_reg;

    always_comb begin
        count_next = count_reg;
        if (kind_reg == K_CLEAR) begin
            count_next = '0;
        end else if (alloc) begin
            count_next = count_reg + CW'(1);
        end
    end

    assign count_ext = {{USED_W{1'b0}}, count_next};

    assign result = {{(M_TDATA_W-O_END){1'b0}}, tick_next, count_ext[USED_W-1:0],
                     rep_sum.dur, rep_sum.total, rep_sum.calls, rep_sum.region,
                     slot_out, status};

    // Controller state, counters and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tick_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_EXEC;
                    end
                    if (m_tvalid_reg && m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        state_reg    <= S_IDLE;
                        tick_reg     <= tick_next;
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            id_reg   <= s_tdata[REGION_W-1:0];
            idx_reg  <= s_tdata[REGION_W+SLOT_IDX_W-1:REGION_W];
        end
        if (fire) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/rpt_checker.sv =====
// ============================================================================
// Region profile table checker
// Port-level assertions on the request and result streams, bound to the top.
// ============================================================================
`include "region_profile_table_defines.svh"

module rpt_checker #(
    parameter int MAX_SLOTS = rpt_pkg::MAX_SLOTS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    // s_tdata, from bit 0: region_id[15:0], slot_index[3:0], zero pad[3:0]
    input logic [rpt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[2:0]
    input logic [rpt_pkg::KIND_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    // m_tdata: status, slot, slot_region, calls, total_ticks, last_duration,
    // slots_used, tick_now, from bit 0
    input logic [rpt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rpt_pkg::*;

    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   used;
    logic                fields_zero;

    assign status      = m_tdata[O_SLOT-1:O_STATUS];
    assign used        = m_tdata[O_TICK-1:O_USED];
    assign fields_zero = (m_tdata[O_USED-1:O_REGION] == '0);

    // A stalled result holds its value.
    `RPT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A request is worked on alone; the next one cannot be accepted in the cycle after.
    `RPT_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted back to back")

    // The slot count never passes the table size.
    `RPT_ASSERT_IMP(a_used_bound, m_tvalid && (MAX_SLOTS < 32), used <= USED_W'(MAX_SLOTS), "slot count beyond table size")

    // A refused or unused result carries no slot contents.
    `RPT_ASSERT_IMP(a_err_zero, m_tvalid && (status != ST_OK), fields_zero && (status <= ST_UNUSED), "error result carries slot data")

endmodule

bind region_profile_table rpt_checker #(.MAX_SLOTS(MAX_SLOTS)) u_rpt_checker (.*);
